FILE: hdl/srme_pkg.sv
// Shared types and constants for the stroke rate median/average filter.
package srme_pkg;

    // Field widths
    localparam int TIME_W   = 32;
    localparam int RATE_W   = 15;
    localparam int RAW_W    = 16;
    localparam int WEIGHT_W = 9;
    localparam int ACC_W    = RATE_W + WEIGHT_W + 1;

    // Q7.8 strokes per minute: 60 * 1000 * 256 / interval_ms
    localparam int                NUM_W     = 24;
    localparam logic [NUM_W-1:0]  NUMERATOR = 24'd15360000;
    localparam int                DCNT_W    = 5;

    localparam logic [RAW_W-1:0]    RAW_MAX      = 16'hFFFF;
    localparam logic [WEIGHT_W-1:0] WEIGHT_FULL  = 9'd256;
    localparam logic [ACC_W-1:0]    ROUND_HALF   = 25'd128;

    // Configuration register map
    localparam int               ADDR_W = 4;
    localparam logic [1:0]       REG_MIN_RATE   = 2'd0;
    localparam logic [1:0]       REG_MAX_RATE   = 2'd1;
    localparam logic [1:0]       REG_NEW_WEIGHT = 2'd2;

    localparam logic [RATE_W-1:0]   MIN_RATE_RST   = 15'd2560;
    localparam logic [RATE_W-1:0]   MAX_RATE_RST   = 15'd16640;
    localparam logic [WEIGHT_W-1:0] NEW_WEIGHT_RST = 9'd205;

    // Input operation codes
    localparam logic OP_STROKE = 1'b0;
    localparam logic OP_STOP   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_RANK,
        ST_MUL_NEW,
        ST_MUL_OLD,
        ST_SEND
    } srme_state_t;

    // Commands from the sequencer to the history store
    typedef struct packed {
        logic              clear;
        logic              push;
        logic [RATE_W-1:0] data;
    } hist_cmd_t;

    // Status from the history store for the current rank candidate
    typedef struct packed {
        logic              empty;
        logic              is_median;
        logic [RATE_W-1:0] cand_value;
    } hist_stat_t;

endpackage

FILE: hdl/srme_div.sv
// Bit-serial restoring divider: fixed rate numerator by a 32-bit interval.
module srme_div
    import srme_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TIME_W-1:0] divisor,
    output logic              done,
    output logic [NUM_W-1:0]  quotient
);

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [DCNT_W-1:0] cnt_reg,   cnt_next;
    logic [TIME_W-1:0] div_reg,   div_next;
    logic [TIME_W-1:0] rem_reg,   rem_next;
    logic [NUM_W-1:0]  num_reg,   num_next;
    logic [NUM_W-1:0]  quo_reg,   quo_next;
    logic [TIME_W:0]   trial;
    logic              fits;

    // Shift one numerator bit into the partial remainder and test it
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, div_reg};

    // Advance one quotient bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            div_next  = divisor;
            rem_next  = '0;
            num_next  = NUMERATOR;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? TIME_W'(trial - {1'b0, div_reg}) : trial[TIME_W-1:0];
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DCNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        rem_reg <= rem_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: hdl/srme_hist.sv
// Rate history ring with a rank test of one candidate entry per cycle.
module srme_hist
    import srme_pkg::*;
#(
    parameter int DEPTH = 3
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  hist_cmd_t                              cmd,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] cand,
    output hist_stat_t                             stat
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);

    logic [RATE_W-1:0] hist_reg [DEPTH];
    logic [IW-1:0]     slot_reg, slot_next;
    logic [FW-1:0]     fill_reg, fill_next;
    logic [RATE_W-1:0] cand_value;
    logic [FW-1:0]     lt_cnt;
    logic [FW-1:0]     le_cnt;
    logic [FW-1:0]     mid;
    logic              cand_valid;

    // Advance write slot and fill count
    always_comb
    begin
        slot_next = slot_reg;
        fill_next = fill_reg;
        if (cmd.clear)
        begin
            slot_next = '0;
            fill_next = '0;
        end
        else if (cmd.push)
        begin
            slot_next = (slot_reg == IW'(DEPTH - 1)) ? '0 : slot_reg + 1'b1;
            if (fill_reg != FW'(DEPTH))
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
            fill_reg <= fill_next;
        end
    end

    // Store an accepted rate
    always_ff @(posedge clk)
    begin
        if (cmd.push && !cmd.clear)
        begin
            hist_reg[slot_reg] <= cmd.data;
        end
    end

    // Count filled entries below and not above the candidate
    assign cand_value = hist_reg[cand];
    assign cand_valid = FW'(cand) < fill_reg;
    assign mid        = fill_reg >> 1;

    always_comb
    begin
        lt_cnt = '0;
        le_cnt = '0;
        for (int j = 0; j < DEPTH; j++)
        begin
            if (FW'(j) < fill_reg)
            begin
                if (hist_reg[j] < cand_value)
                begin
                    lt_cnt = lt_cnt + 1'b1;
                end
                if (hist_reg[j] <= cand_value)
                begin
                    le_cnt = le_cnt + 1'b1;
                end
            end
        end
    end

    assign stat.empty      = (fill_reg == '0);
    assign stat.is_median  = cand_valid && (lt_cnt <= mid) && (mid < le_cnt);
    assign stat.cand_value = cand_value;

endmodule

FILE: hdl/stroke_rate_median_ema_core.sv
// Top level of the stroke rate filter: sequencer, registers and shared multiplier.
//
// Usage:
//   Slave stream: s_tdata carries stroke_time_ms, s_tuser carries operation
//   (0 = stroke at that time, 1 = stop and clear). One result per transaction
//   on the master stream: m_tdata holds current_rate and raw_rate, m_tuser the
//   interval_accepted flag.
//   Stop, first stroke and zero interval go straight to the result; a rejected
//   interval passes the 24-step bit-serial divider and the band check, and an
//   accepted one then also runs the one-candidate-per-cycle median rank search
//   and two passes through the shared 15x9 multiplier (one pass when the
//   history was empty).
//   One item is in flight at a time: s_tready is high only when idle.
//   The result stays on m_tdata/m_tuser while m_tready is low; the next item
//   is taken after the result transaction completes.
//   Reset clears the history, the average and the previous time and loads
//   the band 10.0..65.0 strokes/min and weight 205/256. The user writes the
//   registers through the APB port while no item is in flight; the core does not enforce it.
module stroke_rate_median_ema_core
    import srme_pkg::*;
#(
    parameter int HISTORY_DEPTH = 3
)
(
    input  logic              clk,
    input  logic              rst_n,
    // Configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // Input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // [31:0] stroke_time_ms
    input  logic              s_tuser,   // [0] operation
    // Output stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // [14:0] current_rate, [30:15] raw_rate, [31] zero
    output logic              m_tuser    // [0] interval_accepted
);

    localparam int IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    srme_state_t state_reg, state_next;

    logic [RATE_W-1:0]   min_rate_reg;
    logic [RATE_W-1:0]   max_rate_reg;
    logic [WEIGHT_W-1:0] weight_reg;

    logic [TIME_W-1:0]   prev_time_reg, prev_time_next;
    logic                prev_valid_reg, prev_valid_next;
    logic [RAW_W-1:0]    raw_reg, raw_next;
    logic                accepted_reg, accepted_next;
    logic [RATE_W-1:0]   smoothed_reg, smoothed_next;
    logic [RATE_W-1:0]   median_reg, median_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [IW-1:0]       cand_reg, cand_next;
    logic                was_empty_reg, was_empty_next;

    logic                in_xfer;
    logic                out_xfer;
    logic                cfg_wr;
    logic [TIME_W-1:0]   dt;
    logic                dt_zero;
    logic                div_start;
    logic                div_done;
    logic [NUM_W-1:0]    quotient;
    logic [RAW_W-1:0]    quo_sat;
    logic                in_band;
    logic                last_cand;
    hist_cmd_t           hist_cmd;
    hist_stat_t          hist_stat;
    logic [WEIGHT_W-1:0] w_eff;
    logic [RATE_W-1:0]   mul_a;
    logic [WEIGHT_W-1:0] mul_b;
    logic [RATE_W+WEIGHT_W-1:0] product;
    logic [ACC_W-1:0]    ema_sum;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;
    assign dt       = s_tdata - prev_time_reg;
    assign dt_zero  = (dt == '0);
    assign quo_sat  = (|quotient[NUM_W-1:RAW_W]) ? RAW_MAX : quotient[RAW_W-1:0];
    assign in_band  = (raw_reg >= RAW_W'(min_rate_reg)) && (raw_reg <= RAW_W'(max_rate_reg));
    assign last_cand = (cand_reg == IW'(HISTORY_DEPTH - 1));
    assign w_eff    = (weight_reg > WEIGHT_FULL) ? WEIGHT_FULL : weight_reg;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_rate_reg <= MIN_RATE_RST;
            max_rate_reg <= MAX_RATE_RST;
            weight_reg   <= NEW_WEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_MIN_RATE:   min_rate_reg <= pwdata[RATE_W-1:0];
                REG_MAX_RATE:   max_rate_reg <= pwdata[RATE_W-1:0];
                REG_NEW_WEIGHT: weight_reg   <= pwdata[WEIGHT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_MIN_RATE:   prdata = 32'(min_rate_reg);
            REG_MAX_RATE:   prdata = 32'(max_rate_reg);
            REG_NEW_WEIGHT: prdata = 32'(weight_reg);
            default:        prdata = '0;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = div_start ? ST_DIV : ST_SEND;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = in_band ? ST_RANK : ST_SEND;
            end
            ST_RANK:
            begin
                if (last_cand)
                begin
                    state_next = ST_MUL_NEW;
                end
            end
            ST_MUL_NEW:
            begin
                state_next = was_empty_reg ? ST_SEND : ST_MUL_OLD;
            end
            ST_MUL_OLD:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_xfer)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        s_tready      = 1'b0;
        m_tvalid      = 1'b0;
        div_start     = 1'b0;
        hist_cmd.clear = 1'b0;
        hist_cmd.push  = 1'b0;
        hist_cmd.data  = raw_reg[RATE_W-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    hist_cmd.clear = (s_tuser == OP_STOP);
                    div_start = (s_tuser == OP_STROKE) && prev_valid_reg && !dt_zero;
                end
            end
            ST_CHECK:
            begin
                hist_cmd.push = in_band;
            end
            ST_SEND:
            begin
                m_tvalid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Shared multiplier: new median by weight, then old average by its complement
    assign mul_a   = (state_reg == ST_MUL_OLD) ? smoothed_reg : median_reg;
    assign mul_b   = (state_reg == ST_MUL_OLD) ? WEIGHT_FULL - w_eff : w_eff;
    assign product = mul_a * mul_b;
    assign ema_sum = acc_reg + ACC_W'(product);

    // Datapath registers
    always_comb
    begin
        prev_time_next  = prev_time_reg;
        prev_valid_next = prev_valid_reg;
        raw_next        = raw_reg;
        accepted_next   = accepted_reg;
        smoothed_next   = smoothed_reg;
        median_next     = median_reg;
        acc_next        = acc_reg;
        cand_next       = cand_reg;
        was_empty_next  = was_empty_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    accepted_next = 1'b0;
                    if (s_tuser == OP_STOP)
                    begin
                        prev_time_next  = '0;
                        prev_valid_next = 1'b0;
                        smoothed_next   = '0;
                        raw_next        = '0;
                    end
                    else
                    begin
                        prev_time_next  = s_tdata;
                        prev_valid_next = 1'b1;
                        if (!prev_valid_reg)
                        begin
                            raw_next = '0;
                        end
                        else if (dt_zero)
                        begin
                            raw_next = RAW_MAX;
                        end
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    raw_next = quo_sat;
                end
            end
            ST_CHECK:
            begin
                accepted_next  = in_band;
                was_empty_next = hist_stat.empty;
                cand_next      = '0;
            end
            ST_RANK:
            begin
                if (hist_stat.is_median)
                begin
                    median_next = hist_stat.cand_value;
                end
                if (!last_cand)
                begin
                    cand_next = cand_reg + 1'b1;
                end
            end
            ST_MUL_NEW:
            begin
                if (was_empty_reg)
                begin
                    smoothed_next = median_reg;
                end
                acc_next = ACC_W'(product) + ROUND_HALF;
            end
            ST_MUL_OLD:
            begin
                smoothed_next = ema_sum[RATE_W+7:8];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            prev_time_reg  <= '0;
            prev_valid_reg <= 1'b0;
            smoothed_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            prev_time_reg  <= prev_time_next;
            prev_valid_reg <= prev_valid_next;
            smoothed_reg   <= smoothed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg       <= raw_next;
        accepted_reg  <= accepted_next;
        median_reg    <= median_next;
        acc_reg       <= acc_next;
        cand_reg      <= cand_next;
        was_empty_reg <= was_empty_next;
    end

    srme_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (dt),
        .done     (div_done),
        .quotient (quotient)
    );

    srme_hist
    #(
        .DEPTH (HISTORY_DEPTH)
    )
    u_hist
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (hist_cmd),
        .cand  (cand_reg),
        .stat  (hist_stat)
    );

    // Result fields
    assign m_tdata = {1'b0, raw_reg, smoothed_reg};
    assign m_tuser = accepted_reg;

endmodule

FILE: sim/srme_checker.sv
// Scoreboard for the stroke rate filter: shadows registers, predicts results and compares.
module srme_checker
    import srme_pkg::*;
#(
    parameter int HISTORY_DEPTH = 3
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic [31:0]       prdata,
    input  logic              pready,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [31:0]       s_tdata,   // [31:0] stroke_time_ms
    input  logic              s_tuser,   // [0] operation
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [31:0]       m_tdata,   // [14:0] current_rate, [30:15] raw_rate, [31] zero
    input  logic              m_tuser,   // [0] interval_accepted
    output int                mismatch_count,
    output int                pending_count,
    output int                result_count,
    output int                accepted_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [RATE_W-1:0] current_rate;
        logic [RAW_W-1:0]  raw_rate;
        logic              interval_accepted;
    } rate_result_t;

    // Register shadows
    logic [RATE_W-1:0]   band_low;
    logic [RATE_W-1:0]   band_high;
    logic [WEIGHT_W-1:0] weight;

    // Filter state
    logic [TIME_W-1:0] last_stroke_time;
    logic              last_stroke_seen;
    logic [RATE_W-1:0] history [HISTORY_DEPTH];
    int unsigned       write_slot;
    int unsigned       fill_level;
    logic [RATE_W-1:0] average_rate;

    rate_result_t expected_rates [$];

    // Drop all stroke history, as after reset or a stop
    function automatic void clear_filter();
        last_stroke_time = '0;
        last_stroke_seen = 1'b0;
        for (int i = 0; i < HISTORY_DEPTH; i++)
            history[i] = '0;
        write_slot   = 0;
        fill_level   = 0;
        average_rate = '0;
    endfunction

    // Median over the most recent filled entries; with an even count the upper one
    function automatic logic [RATE_W-1:0] history_median();
        logic [RATE_W-1:0] recent [HISTORY_DEPTH];
        logic [RATE_W-1:0] swap;
        int unsigned       slot;
        for (int i = 0; i < fill_level; i++)
        begin
            slot = (write_slot + HISTORY_DEPTH - 1 - i) % HISTORY_DEPTH;
            recent[i] = history[slot];
        end
        for (int i = 0; i + 1 < fill_level; i++)
        begin
            for (int j = i + 1; j < fill_level; j++)
            begin
                if (recent[i] > recent[j])
                begin
                    swap      = recent[i];
                    recent[i] = recent[j];
                    recent[j] = swap;
                end
            end
        end
        return recent[fill_level / 2];
    endfunction

    // Advance the filter by one transaction and return its result
    function automatic rate_result_t predict_rate(input logic op, input logic [TIME_W-1:0] now);
        rate_result_t      res;
        logic [TIME_W-1:0] interval;
        logic [TIME_W-1:0] quotient;
        logic [RATE_W-1:0] median;
        logic [31:0]       wgt;
        logic [31:0]       sum;
        logic              was_empty;
        res = '0;
        if (op == OP_STOP)
        begin
            clear_filter();
            return res;
        end
        if (last_stroke_seen)
        begin
            interval = now - last_stroke_time;
            if (interval == 0)
                res.raw_rate = RAW_MAX;
            else
            begin
                quotient = 32'(NUMERATOR) / interval;
                res.raw_rate = (quotient > 32'(RAW_MAX)) ? RAW_MAX : quotient[RAW_W-1:0];
                res.interval_accepted = (res.raw_rate >= 16'(band_low)) &&
                                        (res.raw_rate <= 16'(band_high));
            end
        end
        if (res.interval_accepted)
        begin
            was_empty = (fill_level == 0);
            history[write_slot] = res.raw_rate[RATE_W-1:0];
            write_slot = (write_slot + 1) % HISTORY_DEPTH;
            if (fill_level < HISTORY_DEPTH)
                fill_level++;
            median = history_median();
            if (was_empty)
                average_rate = median;
            else
            begin
                wgt = (weight > WEIGHT_FULL) ? 32'(WEIGHT_FULL) : 32'(weight);
                sum = 32'(median) * wgt + 32'(average_rate) * (32'd256 - wgt) + 32'd128;
                average_rate = sum[RATE_W+7:8];
            end
        end
        last_stroke_time = now;
        last_stroke_seen = 1'b1;
        res.current_rate = average_rate;
        return res;
    endfunction

    function automatic logic [31:0] register_value(input logic [ADDR_W-1:0] addr);
        case (addr[ADDR_W-1:2])
            REG_MIN_RATE:   return 32'(band_low);
            REG_MAX_RATE:   return 32'(band_high);
            REG_NEW_WEIGHT: return 32'(weight);
            default:        return '0;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t mismatch: %s", $time, what);
    endtask

    // Watch all three channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        rate_result_t want;
        rate_result_t got;
        logic [31:0]  reg_want;
        if (!rst_n)
        begin
            band_low  = MIN_RATE_RST;
            band_high = MAX_RATE_RST;
            weight    = NEW_WEIGHT_RST;
            clear_filter();
            expected_rates.delete();
            mismatch_count = 0;
            pending_count  = 0;
            result_count   = 0;
            accepted_count = 0;
        end
        else
        begin
            // Track register writes; an unused index changes nothing
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_MIN_RATE:   band_low  = pwdata[RATE_W-1:0];
                    REG_MAX_RATE:   band_high = pwdata[RATE_W-1:0];
                    REG_NEW_WEIGHT: weight    = pwdata[WEIGHT_W-1:0];
                    default:        ;
                endcase
            end

            // Check register reads
            if (psel && penable && !pwrite && pready)
            begin
                reg_want = register_value(paddr);
                if (prdata !== reg_want)
                    report_mismatch($sformatf("read addr %0d: expected %0d, got %0d",
                                              paddr, reg_want, prdata));
            end

            // Compare a result transaction against the oldest prediction
            if (m_tvalid && m_tready)
            begin
                got.current_rate      = m_tdata[RATE_W-1:0];
                got.raw_rate          = m_tdata[RATE_W+RAW_W-1:RATE_W];
                got.interval_accepted = m_tuser;
                result_count++;
                if (m_tuser === 1'b1)
                    accepted_count++;
                if (expected_rates.size() == 0)
                    report_mismatch($sformatf("unexpected result: rate %0d raw %0d accepted %0b",
                                              got.current_rate, got.raw_rate,
                                              got.interval_accepted));
                else
                begin
                    want = expected_rates.pop_front();
                    if (got !== want || m_tdata[31] !== 1'b0)
                        report_mismatch($sformatf(
                            "rate %0d/%0d raw %0d/%0d accepted %0b/%0b pad %b (exp/act)",
                            want.current_rate, got.current_rate, want.raw_rate, got.raw_rate,
                            want.interval_accepted, got.interval_accepted, m_tdata[31]));
                end
            end

            // Predict the result of an input transaction
            if (s_tvalid && s_tready)
                expected_rates.push_back(predict_rate(s_tuser, s_tdata));

            pending_count = expected_rates.size();
        end
    end

endmodule

FILE: sim/tb_top.sv
// Testbench top for the stroke rate filter: clock, reset, stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import srme_pkg::*;

    localparam int          HISTORY_DEPTH = 3;
    localparam int          PHASE_ITEMS   = 230;
    localparam int          PHASE_COUNT   = 8;
    localparam int          LONG_HOLD     = 400;
    localparam int          END_WAIT      = 60;
    localparam int          CYCLE_LIMIT   = 600000;
    localparam logic [1:0]  REG_SPARE     = 2'd3;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              s_tvalid;
    logic              s_tready;
    logic [31:0]       s_tdata;   // [31:0] stroke_time_ms
    logic              s_tuser;   // [0] operation
    logic              m_tvalid;
    logic              m_tready;
    logic [31:0]       m_tdata;   // [14:0] current_rate, [30:15] raw_rate, [31] zero
    logic              m_tuser;   // [0] interval_accepted

    int mismatch_count;
    int pending_count;
    int result_count;
    int accepted_count;

    // Stimulus control shared with the receiver
    logic        no_idle;
    logic        hold_request;
    logic [31:0] last_time;
    int unsigned stim_low;
    int unsigned stim_high;
    int          items_sent;
    int          stops_sent;
    int          cycle_count;

    stroke_rate_median_ema_core #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    srme_checker #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .result_count   (result_count),
        .accepted_count (accepted_count)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("[stroke_rate_median_ema_core] ERROR");
        $finish;
    end

    // One APB transfer: setup cycle and access cycle, then psel and penable drop
    task automatic apb_access(input logic is_write, input logic [1:0] index,
                              input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= ADDR_W'({index, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Write the band and weight with junk above the register widths, then read back
    task automatic set_rate_band(input int unsigned low, input int unsigned high,
                                 input int unsigned wgt);
        apb_access(1'b1, REG_MIN_RATE, ($urandom() << RATE_W) | low);
        apb_access(1'b1, REG_MAX_RATE, ($urandom() << RATE_W) | high);
        apb_access(1'b1, REG_NEW_WEIGHT, ($urandom() << WEIGHT_W) | wgt);
        apb_access(1'b1, REG_SPARE, $urandom());
        apb_access(1'b0, REG_MIN_RATE, '0);
        apb_access(1'b0, REG_MAX_RATE, '0);
        apb_access(1'b0, REG_NEW_WEIGHT, '0);
        stim_low  = low;
        stim_high = high;
    endtask

    // Offer one input transaction after a random gap and hold it until taken
    task automatic send_item(input logic op, input logic [31:0] stamp);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= stamp;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        items_sent++;
        if (op == OP_STOP)
            stops_sent++;
    endtask

    task automatic stroke_at(input logic [31:0] stamp);
        send_item(OP_STROKE, stamp);
        last_time = stamp;
    endtask

    // Stop offering and wait until every predicted result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        wait (pending_count == 0);
        @(negedge clk);
    endtask

    // Result receiver with random stalls and an occasional long hold-off
    initial
    begin
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            @(negedge clk);
        end
    end

    // Reset, stimulus and verdict
    initial
    begin
        int unsigned r;
        int unsigned target;
        logic [31:0] gap_ms;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = OP_STROKE;
        no_idle      = 1'b0;
        hold_request = 1'b0;
        last_time    = '0;
        stim_low     = MIN_RATE_RST;
        stim_high    = MAX_RATE_RST;
        items_sent   = 0;
        stops_sent   = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed sequence at the reset band 10.0..65.0 and weight 205
        send_item(OP_STOP, 32'hFFFF_FFFF);   // stop with nothing stored
        stroke_at(32'd1000);                 // first stroke, no interval yet
        stroke_at(32'd1000);                 // zero interval saturates, rejected
        stroke_at(32'd2000);                 // first accepted rate loads the average
        stroke_at(32'd3000);                 // two entries: median is the larger
        stroke_at(32'd3500);                 // above the band
        stroke_at(32'd4424);                 // just inside the top of the band
        stroke_at(32'd5347);                 // just above the top of the band
        stroke_at(32'd11347);                // exactly the bottom of the band
        stroke_at(32'd17348);                // just below the bottom of the band
        stroke_at(32'd18348);                // history full
        stroke_at(32'd19548);                // median of three
        stroke_at(32'hFFFF_FF00);            // huge interval, rate zero
        stroke_at(32'h0000_0300);            // interval across the time wrap
        stroke_at(32'h0000_0301);            // one millisecond saturates
        stroke_at(32'h0000_03EB);            // last interval that saturates
        stroke_at(32'h0000_04D6);            // first interval below saturation
        send_item(OP_STOP, 32'h0000_0000);   // clear everything
        stroke_at(32'hFFFF_FFFF);            // first stroke after stop
        stroke_at(32'h0000_0400);            // wrapped interval refills the history
        stroke_at(32'hFFFF_FFFF);            // near-full-range interval

        // Random phases, one register setting each
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            drain_results();
            case (phase)
                0: hold_request = 1'b1;
                1: set_rate_band(0, 16895, 256);
                2: set_rate_band(16895, 0, 0);
                3: set_rate_band(5000, 5000, 511);
                4: set_rate_band($urandom_range(0, 8000), $urandom_range(8000, 16895),
                                 $urandom_range(0, 511));
                5: set_rate_band(0, 16895, 1);
                6: set_rate_band($urandom_range(0, 16895), $urandom_range(0, 16895),
                                 $urandom_range(0, 511));
                default:
                begin
                    set_rate_band(MIN_RATE_RST, MAX_RATE_RST, 128);
                    hold_request = 1'b1;
                end
            endcase
            no_idle = (phase == 1 || phase == 6);
            repeat (PHASE_ITEMS)
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    send_item(OP_STOP, $urandom());
                else if (r < 9)
                    stroke_at($urandom());
                else
                begin
                    if (r < 13)
                        gap_ms = $urandom_range(0, 240);
                    else if (r < 16)
                        gap_ms = $urandom();
                    else if (r < 18)
                        gap_ms = '0;
                    else if (stim_low <= stim_high)
                    begin
                        // Aim at a rate inside the band
                        target = $urandom_range(stim_high, stim_low);
                        if (target == 0)
                            gap_ms = $urandom_range(32'hFFFF_FFFF, 32'(NUMERATOR) + 1);
                        else
                            gap_ms = 32'(NUMERATOR) / target;
                    end
                    else
                        gap_ms = $urandom_range(900, 6100);
                    stroke_at(last_time + gap_ms);
                end
            end
        end

        // Let the last results come home
        drain_results();
        repeat (END_WAIT) @(negedge clk);

        $display("ran %0d input transactions (%0d stops) over %0d register settings",
                 items_sent, stops_sent, PHASE_COUNT);
        $display("checked %0d results, %0d with the interval accepted",
                 result_count, accepted_count);
        if (pending_count != 0)
            $display("%0d predicted results never arrived", pending_count);
        if (mismatch_count == 0 && pending_count == 0)
            $display("[stroke_rate_median_ema_core] OK");
        else
            $display("[stroke_rate_median_ema_core] ERROR");
        $finish;
    end

endmodule
